// ===== rtl/vpm_pkg.sv =====
`timescale 1ns / 1ps

package vpm_pkg;

   localparam int CHANNELS     = 8;
   localparam int BISECT_STEPS = 17;

   localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STEP_W    = $clog2(BISECT_STEPS);

   localparam int ENV_W    = 32;
   localparam int ALPHA_W  = 24;
   localparam int REF_W    = 15;
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 17;
   localparam int PEAK_W   = 16;
   localparam int LEVEL_W  = 16;
   localparam int GAIN_W   = 20;
   localparam int HALF_W   = ENV_W / 2;
   localparam int PART_W   = ALPHA_W + HALF_W;
   localparam int PROD_W   = PEAK_W + GAIN_W;

   localparam logic [GAIN_W-1:0]  GAIN_LOW    = 20'd6554;
   localparam logic [GAIN_W-1:0]  GAIN_HIGH   = 20'd655360;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd16776051;
   localparam logic [REF_W-1:0]   REF_RESET   = 15'd4125;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ALPHA_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_LEVEL     = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_BISECT,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/vpm_ram.sv =====
`timescale 1ns / 1ps

module vpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vu_peak_meter_gain_finder.sv =====
`timescale 1ns / 1ps

// Requests are taken only in the idle state: req_stall holds off a new request until
// the last one has left the output state. A request passes the envelope memory read
// and split multiply, then the write-back, then the BISECT_STEPS gain-search steps if
// it is a last request, then the output state, which waits while rsp_stall holds it.
// Reset: control and configuration registers return to defaults, envelopes read as
// zero through per-channel valid flags, peak cleared; no memory clearing pass.
module vu_peak_meter_gain_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_channel,
   input  logic signed [15:0]                req_sample,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_level,
   output logic                              rsp_gain_valid,
   output logic [19:0]                       rsp_gain,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   vpm_pkg::state_type state_ff, state_in;

   logic [vpm_pkg::ALPHA_W-1:0]   alpha_ff;
   logic [vpm_pkg::REF_W-1:0]     ref_ff;

   logic [vpm_pkg::CH_ADDR_W-1:0] addr_ff;
   logic                          in_range_ff;
   logic [vpm_pkg::MAG_W-1:0]     mag_ff;
   logic                          last_ff;

   logic [vpm_pkg::CHANNELS-1:0]  env_valid_ff, env_valid_in;
   logic [vpm_pkg::PART_W-1:0]    part_hi_ff, part_lo_ff;
   logic [vpm_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [vpm_pkg::PEAK_W-1:0]    peak_ff, peak_in;
   logic [vpm_pkg::GAIN_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [vpm_pkg::STEP_W-1:0]    step_ff, step_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vpm_pkg::LEVEL_W-1:0]   rsp_level_ff;
   logic                          rsp_gain_valid_ff;
   logic [vpm_pkg::GAIN_W-1:0]    rsp_gain_ff;

   logic                          req_accept;
   logic                          out_load;
   logic                          ram_we;
   logic [vpm_pkg::ENV_W-1:0]     ram_rdata;
   logic [vpm_pkg::ENV_W-1:0]     env_old;
   logic [vpm_pkg::PART_W+vpm_pkg::HALF_W-1:0] decay_sum;
   logic [vpm_pkg::ENV_W-1:0]     decayed, fresh, env_next;
   logic [vpm_pkg::GAIN_W:0]      bound_sum;
   logic [vpm_pkg::GAIN_W-1:0]    mid;
   logic [vpm_pkg::PROD_W-1:0]    peak_prod, target;
   logic [vpm_pkg::MAG_W-1:0]     req_mag;
   logic                          req_in_range;

   assign req_stall  = (state_ff != vpm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign req_mag = req_sample[15] ? (17'h10000 - {1'b0, req_sample})
                                   : {1'b0, req_sample};
   assign req_in_range = (int'(req_channel) < vpm_pkg::CHANNELS);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= vpm_pkg::ALPHA_RESET;
         ref_ff   <= vpm_pkg::REF_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vpm_pkg::CSR_RELEASE_ALPHA: alpha_ff <= csr_wdata[vpm_pkg::ALPHA_W-1:0];
            vpm_pkg::CSR_REF_LEVEL:     ref_ff   <= csr_wdata[vpm_pkg::REF_W-1:0];
            default: ;
         endcase
      end
   end

   vpm_ram #(
      .WIDTH (vpm_pkg::ENV_W),
      .DEPTH (vpm_pkg::CHANNELS)
   ) u_env_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (env_next),
      .rd_en   (req_accept),
      .rd_addr (vpm_pkg::CH_ADDR_W'(req_channel)),
      .rd_data (ram_rdata)
   );

   // envelope datapath
   assign env_old   = env_valid_ff[addr_ff] ? ram_rdata : '0;
   assign decay_sum = {part_hi_ff, {vpm_pkg::HALF_W{1'b0}}}
                    + {{vpm_pkg::HALF_W{1'b0}}, part_lo_ff};
   assign decayed   = decay_sum[vpm_pkg::PART_W+vpm_pkg::HALF_W-1 -: vpm_pkg::ENV_W];
   assign fresh     = {mag_ff[vpm_pkg::HALF_W-1:0], {vpm_pkg::HALF_W{1'b0}}}
                    | {mag_ff[vpm_pkg::HALF_W], {(vpm_pkg::ENV_W-1){1'b0}}};
   assign env_next  = (decayed > fresh) ? decayed : fresh;
   assign ram_we    = (state_ff == vpm_pkg::ST_MUL) && in_range_ff;

   // bisection datapath
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = bound_sum[vpm_pkg::GAIN_W:1];
   assign peak_prod = vpm_pkg::PROD_W'(peak_ff) * vpm_pkg::PROD_W'(mid);
   assign target    = vpm_pkg::PROD_W'({ref_ff, 16'd0});

   assign out_load  = (state_ff == vpm_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      env_valid_in = env_valid_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         vpm_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = vpm_pkg::ST_READ;
            end
         end
         vpm_pkg::ST_READ: begin
            state_in = vpm_pkg::ST_MUL;
         end
         vpm_pkg::ST_MUL: begin
            level_in = '0;
            if (in_range_ff) begin
               env_valid_in[addr_ff] = 1'b1;
               level_in = env_next[vpm_pkg::ENV_W-1 -: vpm_pkg::LEVEL_W];
               if (mag_ff > vpm_pkg::MAG_W'(peak_ff)) begin
                  peak_in = mag_ff[vpm_pkg::PEAK_W-1:0];
               end
            end
            lo_in   = vpm_pkg::GAIN_LOW;
            hi_in   = vpm_pkg::GAIN_HIGH;
            step_in = '0;
            state_in = last_ff ? vpm_pkg::ST_BISECT : vpm_pkg::ST_OUT;
         end
         vpm_pkg::ST_BISECT: begin
            if (peak_prod < target) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == vpm_pkg::STEP_W'(vpm_pkg::BISECT_STEPS - 1)) begin
               state_in = vpm_pkg::ST_OUT;
            end
         end
         vpm_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = vpm_pkg::ST_IDLE;
               if (last_ff) begin
                  env_valid_in = '0;
                  peak_in      = '0;
               end
            end
         end
         default: state_in = vpm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpm_pkg::ST_IDLE;
         env_valid_ff <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_valid_ff <= env_valid_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff     <= vpm_pkg::CH_ADDR_W'(req_channel);
         in_range_ff <= req_in_range;
         mag_ff      <= req_mag;
         last_ff     <= req_last;
      end
      if (state_ff == vpm_pkg::ST_READ) begin
         part_hi_ff <= vpm_pkg::PART_W'(alpha_ff) * vpm_pkg::PART_W'(env_old[31:16]);
         part_lo_ff <= vpm_pkg::PART_W'(alpha_ff) * vpm_pkg::PART_W'(env_old[15:0]);
      end
      level_ff <= level_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      step_ff  <= step_in;
      if (out_load) begin
         rsp_level_ff      <= level_ff;
         rsp_gain_valid_ff <= last_ff;
         rsp_gain_ff       <= last_ff ? mid : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_gain_valid = rsp_gain_valid_ff;
   assign rsp_gain       = rsp_gain_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == vpm_pkg::ST_OUT))
      else $error("response raised outside output state");

   a_gain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_gain_valid_ff) |-> (rsp_gain_ff == '0))
      else $error("gain nonzero without gain_valid");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == vpm_pkg::ST_READ))
      else $error("accepted request did not start memory read");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vpm_pkg::ST_BISECT) |-> (lo_ff <= hi_ff))
      else $error("bisection bounds crossed");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> (env_valid_ff == '0 && peak_ff == '0))
      else $error("state not cleared after last request");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int CALM_TAIL      = 200;
   localparam int DRAIN_TAIL     = 3 + vpm_pkg::BISECT_STEPS + 10;

   localparam logic [vpm_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [vpm_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [vpm_pkg::LEVEL_W-1:0] level;
      logic                        gain_valid;
      logic [vpm_pkg::GAIN_W-1:0]  gain;
   } meter_result_type;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                     kind;
      logic [2:0]                       channel;
      logic signed [15:0]               sample;
      logic                             last;
      logic                             typed;
      logic [vpm_pkg::LEVEL_W-1:0]      want_level;
      logic [vpm_pkg::CSR_IDX_W-1:0]    csr_idx;
      logic [vpm_pkg::CSR_DATA_W-1:0]   csr_data;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 29;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQUEST, 3'd0, 16'sd100, 1'b0, 1'b1, 16'd100, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd1, 16'sh8000, 1'b0, 1'b1, 16'd32768, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd2, 16'sd32767, 1'b0, 1'b1, 16'd32767, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd7, -16'sd1, 1'b0, 1'b1, 16'd1, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd1, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd3, 16'sd5, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      // silent set
      '{ROW_REQUEST, 3'd4, 16'sd0, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_REF_LEVEL, 24'd0},
      '{ROW_REQUEST, 3'd5, 16'sd1000, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd6, 16'sd500, 1'b0, 1'b1, 16'd500, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd6, 16'sd0, 1'b0, 1'b1, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd6, -16'sd2, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'hFFFFFF},
      '{ROW_REQUEST, 3'd6, -16'sd300, 1'b0, 1'b1, 16'd300, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd6, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd6, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_REF_LEVEL, 24'h007FFF},
      '{ROW_REQUEST, 3'd2, 16'sd32767, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      // unmapped indexes must not touch either register
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, CSR_SPARE_LO, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, CSR_SPARE_HI, 24'd0},
      '{ROW_REQUEST, 3'd3, 16'sd1000, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd3, 16'sd0, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA,
        vpm_pkg::ALPHA_RESET},
      '{ROW_CSR, 3'd0, 16'sd0, 1'b0, 1'b0, 16'd0, vpm_pkg::CSR_REF_LEVEL,
        24'hFF8000 | 24'(vpm_pkg::REF_RESET)},
      '{ROW_REQUEST, 3'd1, 16'sh8000, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd0, 16'sd12345, 1'b0, 1'b1, 16'd12345, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0},
      '{ROW_REQUEST, 3'd0, 16'sd0, 1'b1, 1'b0, 16'd0, vpm_pkg::CSR_RELEASE_ALPHA, 24'd0}
   };

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [2:0]                        req_channel;
   logic signed [15:0]                req_sample;
   logic                              req_last;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [15:0]                       rsp_level;
   logic                              rsp_gain_valid;
   logic [19:0]                       rsp_gain;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [vpm_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [vpm_pkg::CSR_DATA_W-1:0]    csr_wdata;

   logic idling          = 1'b0;
   int   long_hold_asked = 0;
   int   long_hold_served = 0;
   int   stall_left      = 0;
   int   mismatch_count  = 0;

   // predictor state
   logic [vpm_pkg::ALPHA_W-1:0] meter_alpha;
   logic [vpm_pkg::REF_W-1:0]   meter_target;
   logic [vpm_pkg::ENV_W-1:0]   envelopes [vpm_pkg::CHANNELS];
   logic [vpm_pkg::PEAK_W-1:0]  set_peak;

   meter_result_type meter_expect [$];

   vu_peak_meter_gain_finder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_channel   (req_channel),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_gain_valid(rsp_gain_valid),
      .rsp_gain      (rsp_gain),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_meter_set();
      foreach (envelopes[i]) envelopes[i] = '0;
      set_peak = '0;
   endfunction

   function automatic meter_result_type meter_predict(logic [2:0] ch,
                                                      logic signed [15:0] smp, logic lst);
      meter_result_type               r;
      logic [vpm_pkg::MAG_W-1:0]      mag;
      logic [55:0]                    decayed;
      logic [55:0]                    fresh;
      logic [vpm_pkg::GAIN_W-1:0]     lo;
      logic [vpm_pkg::GAIN_W-1:0]     hi;
      logic [vpm_pkg::GAIN_W-1:0]     mid;
      logic [39:0]                    target;
      r = '0;
      mag = smp[15] ? vpm_pkg::MAG_W'(-int'(smp)) : vpm_pkg::MAG_W'(smp);
      if (int'(ch) < vpm_pkg::CHANNELS) begin
         decayed = (56'(meter_alpha) * 56'(envelopes[ch])) >> 24;
         fresh = 56'(mag) << 16;
         if (fresh > decayed) decayed = fresh;
         envelopes[ch] = decayed[31:0];
         r.level = decayed[31:16];
         if (mag > vpm_pkg::MAG_W'(set_peak)) set_peak = mag[vpm_pkg::PEAK_W-1:0];
      end
      if (lst) begin
         lo = vpm_pkg::GAIN_LOW;
         hi = vpm_pkg::GAIN_HIGH;
         target = 40'(meter_target) << 16;
         repeat (vpm_pkg::BISECT_STEPS) begin
            mid = vpm_pkg::GAIN_W'((21'(lo) + 21'(hi)) >> 1);
            if (40'(set_peak) * 40'(mid) < target) lo = mid;
            else hi = mid;
         end
         r.gain = vpm_pkg::GAIN_W'((21'(lo) + 21'(hi)) >> 1);
         r.gain_valid = 1'b1;
         clear_meter_set();
      end
      return r;
   endfunction

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sd32767;
         2: return 16'sd0;
         3, 4: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain_readings();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (meter_expect.size() != 0);
   endtask

   task automatic write_register(logic [vpm_pkg::CSR_IDX_W-1:0] idx,
                                 logic [vpm_pkg::CSR_DATA_W-1:0] data);
      drain_readings();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == vpm_pkg::CSR_RELEASE_ALPHA) meter_alpha = data[vpm_pkg::ALPHA_W-1:0];
      else if (idx == vpm_pkg::CSR_REF_LEVEL) meter_target = data[vpm_pkg::REF_W-1:0];
   endtask

   task automatic offer_request(logic [2:0] ch, logic signed [15:0] smp, logic lst,
                                logic typed, logic [vpm_pkg::LEVEL_W-1:0] want_level);
      meter_result_type predicted;
      csr_valid <= 1'b0;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= smp;
      req_last    <= lst;
      do @(posedge clock); while (req_stall);
      predicted = meter_predict(ch, smp, lst);
      if (typed) predicted = {want_level, 1'b0, vpm_pkg::GAIN_W'(0)};
      meter_expect.push_back(predicted);
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (long_hold_served != long_hold_asked) begin
         rsp_stall        <= 1'b1;
         stall_left       <= LONG_HOLD - 1;
         long_hold_served <= long_hold_asked;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_responses
      meter_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (meter_expect.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_level, 0);
         end else begin
            want = meter_expect.pop_front();
            if (rsp_level !== want.level)
               report_mismatch("level", rsp_level, want.level);
            if (rsp_gain_valid !== want.gain_valid)
               report_mismatch("gain_valid", rsp_gain_valid, want.gain_valid);
            if (rsp_gain !== want.gain)
               report_mismatch("gain", rsp_gain, want.gain);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin : stimulus
      directed_row_type                row;
      int                              sent;
      int                              set_len;
      int                              set_count;
      logic                            hold_done;
      logic                            hold_now;
      logic                            pause_done;
      logic                            idle_pick;
      logic [vpm_pkg::ALPHA_W-1:0]     alpha_pick;
      logic [vpm_pkg::REF_W-1:0]       target_pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_channel = '0;
      req_sample  = '0;
      req_last    = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      meter_alpha  = vpm_pkg::ALPHA_RESET;
      meter_target = vpm_pkg::REF_RESET;
      clear_meter_set();
      sent       = 0;
      set_count  = 0;
      hold_done  = 1'b0;
      hold_now   = 1'b0;
      pause_done = 1'b0;
      repeat (12) @(posedge clock);
      reset  <= 1'b0;
      idling <= 1'b1;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR)
            write_register(row.csr_idx, row.csr_data);
         else
            offer_request(row.channel, row.sample, row.last, row.typed, row.want_level);
      end

      while (sent < RANDOM_ITEMS) begin
         if (set_count % 8 == 0) begin
            case ($urandom_range(0, 4))
               0: alpha_pick = '0;
               1: alpha_pick = '1;
               2: alpha_pick = vpm_pkg::ALPHA_RESET;
               3: alpha_pick = vpm_pkg::ALPHA_W'($urandom);
               default: alpha_pick = {8'hFF, 16'($urandom)};
            endcase
            case ($urandom_range(0, 4))
               0: target_pick = '0;
               1: target_pick = '1;
               2: target_pick = vpm_pkg::REF_RESET;
               default: target_pick = vpm_pkg::REF_W'($urandom);
            endcase
            write_register(vpm_pkg::CSR_RELEASE_ALPHA, alpha_pick);
            write_register(vpm_pkg::CSR_REF_LEVEL, {9'($urandom), target_pick});
            if ($urandom_range(0, 3) == 0)
               write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                              vpm_pkg::CSR_DATA_W'($urandom));
         end
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(1, 24);
         idle_pick = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         hold_now = 1'b0;
         // hold the response side off while requests keep coming
         if (!hold_done && sent >= 500 && set_count % 8 == 1) begin
            long_hold_asked <= long_hold_asked + 1;
            hold_done = 1'b1;
            hold_now = 1'b1;
            idle_pick = 1'b0;
            set_len = 60;
         end
         idling <= idle_pick;
         if (!pause_done && sent >= 1000) begin
            drain_readings();
            pause_done = 1'b1;
         end
         if (!hold_now && $urandom_range(0, 9) == 0) begin
            offer_request(3'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
            set_len = 1;
         end else begin
            for (int k = 0; k < set_len; k++)
               offer_request(3'($urandom), rand_sample(), k == set_len - 1, 1'b0, '0);
         end
         sent += set_len;
         set_count++;
      end

      idling <= 1'b0;
      drain_readings();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/vpm_pkg.sv
rtl/vpm_ram.sv
rtl/vu_peak_meter_gain_finder.sv
dv/tb.sv
